@@ hw/rtl/nnfs_pkg.sv @@
// Shared types, constants and helpers for the nearest-neighbor frame scaler.
// Used by nearest_neighbor_frame_scaler and its testbench; depends on nothing else.
package nnfs_pkg;

    // Default frame store geometry, handed to the top level parameters.
    localparam int MAX_WIDTH_DEF  = 512;
    localparam int MAX_HEIGHT_DEF = 256;

    // Pixel format is fixed by the RGB565 payload.
    localparam int PIXEL_BITS = 16;

    // Configuration port.
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int WIDTH_CFG_W  = 10;
    localparam int HEIGHT_CFG_W = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [WIDTH_CFG_W-1:0]  SRC_WIDTH_RST  = 10'd320;
    localparam logic [HEIGHT_CFG_W-1:0] SRC_HEIGHT_RST = 9'd240;
    localparam logic [WIDTH_CFG_W-1:0]  DST_WIDTH_RST  = 10'd320;
    localparam logic [HEIGHT_CFG_W-1:0] DST_HEIGHT_RST = 9'd240;

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EMIT = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [PIXEL_BITS-1:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  last_pixel;
    } out_t;

    // A size of zero counts as one, anything above the maximum as the maximum.
    function automatic int unsigned clamp_size(input int unsigned value,
                                               input int unsigned max_size);
        int unsigned result;
        if (value == 0)
        begin
            result = 1;
        end
        else if (value > max_size)
        begin
            result = max_size;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

@@ hw/rtl/nnfs_div.sv @@
// Restoring serial divider, one quotient bit per cycle, for the scaler's setup.
// Depends on nothing; instantiated by nearest_neighbor_frame_scaler.
module nnfs_div #(
    parameter int W = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [W:0] shifted;
    logic [W:0] diff;
    logic       fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder always stays below the divisor.
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/nearest_neighbor_frame_scaler.sv @@
// Nearest-neighbor frame scaler: top level with the frame store and request sequencer.
// Depends on nnfs_pkg and instantiates nnfs_div.
//
// A source frame of RGB565 pixels is loaded in raster order with load requests, and
// every emit request returns the next destination pixel in raster order, taken from
// source column floor(x*src_width/dst_width) and row floor(y*src_height/dst_height);
// the final pixel of a destination frame carries last_pixel and the position wraps.
// Loads stream at one per cycle while the sequencer is idle and no register write is
// offered. For an emit request the store address is formed with one multiply-add and
// registered, the frame store (a synchronous memory of MAX_WIDTH*MAX_HEIGHT entries
// with one write port and one read port) is read, and the pixel is placed in the
// output register; the next request is taken once the pixel has been placed, even if
// that result still waits to be taken.
// Source coordinates are stepped incrementally with a precomputed quotient and
// remainder of src/dst for columns and rows. Those are produced by a shared serial
// divider after reset and after every register write, during which no request is taken.
// Any register write also restarts source loading and the output position at zero.
// Sizes of zero count as one, sizes above the maximum as the maximum.
module nearest_neighbor_frame_scaler #(
    parameter int MAX_WIDTH  = nnfs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = nnfs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  nnfs_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output nnfs_pkg::out_t                     out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nnfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [nnfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W    = $clog2(MAX_HEIGHT + 1);
    localparam int DIV_W       = (WIDTH_W > HEIGHT_W) ? WIDTH_W : HEIGHT_W;
    localparam int PROD_W      = WIDTH_W + HEIGHT_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_COL_GO,
        ST_COL_WAIT,
        ST_ROW_GO,
        ST_ROW_WAIT,
        ST_IDLE,
        ST_READ,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    // Size registers, kept as written.
    logic [nnfs_pkg::WIDTH_CFG_W-1:0]  src_width_reg, src_width_next;
    logic [nnfs_pkg::HEIGHT_CFG_W-1:0] src_height_reg, src_height_next;
    logic [nnfs_pkg::WIDTH_CFG_W-1:0]  dst_width_reg, dst_width_next;
    logic [nnfs_pkg::HEIGHT_CFG_W-1:0] dst_height_reg, dst_height_next;

    // Per-frame stepping constants from the divider, and the source frame size.
    logic [WIDTH_W-1:0]  col_q_reg, col_q_next;
    logic [WIDTH_W-1:0]  col_r_reg, col_r_next;
    logic [HEIGHT_W-1:0] row_q_reg, row_q_next;
    logic [HEIGHT_W-1:0] row_r_reg, row_r_next;
    logic [ADDR_W:0]     frame_size_reg, frame_size_next;

    // Output position and the matching source coordinates.
    logic [WIDTH_W-1:0]  col_pos_reg, col_pos_next;
    logic [HEIGHT_W-1:0] row_pos_reg, row_pos_next;
    logic [WIDTH_W-1:0]  col_src_reg, col_src_next;
    logic [WIDTH_W-1:0]  col_rem_reg, col_rem_next;
    logic [HEIGHT_W-1:0] row_src_reg, row_src_next;
    logic [HEIGHT_W-1:0] row_rem_reg, row_rem_next;
    logic [ADDR_W-1:0]   load_ptr_reg, load_ptr_next;

    // Emit path.
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    nnfs_pkg::out_t      out_data_reg, out_data_next;

    // Frame store.
    logic [nnfs_pkg::PIXEL_BITS-1:0] store_mem [STORE_DEPTH];
    logic [nnfs_pkg::PIXEL_BITS-1:0] mem_rdata_reg;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_waddr;

    // Clamped sizes.
    logic [WIDTH_W-1:0]  sw;
    logic [HEIGHT_W-1:0] sh;
    logic [WIDTH_W-1:0]  dw;
    logic [HEIGHT_W-1:0] dh;

    // Divider hookup.
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DIV_W-1:0] div_rem;

    // Combinational helpers.
    logic              in_acc;
    logic              is_load;
    logic              out_free;
    logic              cfg_write;
    logic              row_end;
    logic              frame_end;
    logic [WIDTH_W:0]  col_sum;
    logic              col_wrap;
    logic [HEIGHT_W:0] row_sum;
    logic              row_wrap;
    logic [PROD_W-1:0] row_base;
    logic [PROD_W-1:0] frame_prod;
    logic [ADDR_W:0]   ptr_inc;

    assign sw = WIDTH_W'(nnfs_pkg::clamp_size(32'(src_width_reg), MAX_WIDTH));
    assign sh = HEIGHT_W'(nnfs_pkg::clamp_size(32'(src_height_reg), MAX_HEIGHT));
    assign dw = WIDTH_W'(nnfs_pkg::clamp_size(32'(dst_width_reg), MAX_WIDTH));
    assign dh = HEIGHT_W'(nnfs_pkg::clamp_size(32'(dst_height_reg), MAX_HEIGHT));

    // The divider serves columns first, then rows.
    assign div_start    = (state_reg == ST_COL_GO) || (state_reg == ST_ROW_GO);
    assign div_dividend = (state_reg == ST_COL_GO) ? DIV_W'(sw) : DIV_W'(sh);
    assign div_divisor  = (state_reg == ST_COL_GO) ? DIV_W'(dw) : DIV_W'(dh);

    nnfs_div #(
        .W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Register writes win over requests in the same cycle.
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_acc   = in_valid && in_ready;
    assign is_load  = (in_data.req_type == nnfs_pkg::REQ_LOAD);
    assign out_free = !out_valid_reg || out_ready;

    // Store address of the current output pixel: one multiply-add.
    assign row_base   = PROD_W'(row_src_reg) * PROD_W'(sw);
    assign frame_prod = PROD_W'(sw) * PROD_W'(sh);

    // Position stepping. The remainder stays below the destination size, so a single
    // compare and subtract carries it into the source coordinate.
    assign row_end   = (col_pos_reg == (dw - 1'b1));
    assign frame_end = row_end && (row_pos_reg == (dh - 1'b1));
    assign col_sum   = {1'b0, col_rem_reg} + {1'b0, col_r_reg};
    assign col_wrap  = (col_sum >= {1'b0, dw});
    assign row_sum   = {1'b0, row_rem_reg} + {1'b0, row_r_reg};
    assign row_wrap  = (row_sum >= {1'b0, dh});

    // Loads: the pointer restarts at the end of the source frame.
    assign mem_waddr = ({1'b0, load_ptr_reg} >= frame_size_reg) ? '0 : load_ptr_reg;
    assign mem_we    = in_acc && is_load;
    assign ptr_inc   = {1'b0, mem_waddr} + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        dst_width_next  = dst_width_reg;
        dst_height_next = dst_height_reg;
        col_q_next      = col_q_reg;
        col_r_next      = col_r_reg;
        row_q_next      = row_q_reg;
        row_r_next      = row_r_reg;
        frame_size_next = frame_size_reg;
        col_pos_next    = col_pos_reg;
        row_pos_next    = row_pos_reg;
        col_src_next    = col_src_reg;
        col_rem_next    = col_rem_reg;
        row_src_next    = row_src_reg;
        row_rem_next    = row_rem_reg;
        load_ptr_next   = load_ptr_reg;
        rd_addr_next    = rd_addr_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        cfg_write       = 1'b0;

        case (state_reg)
            ST_COL_GO:
            begin
                state_next = ST_COL_WAIT;
            end
            ST_COL_WAIT:
            begin
                if (div_done)
                begin
                    col_q_next = WIDTH_W'(div_quo);
                    col_r_next = WIDTH_W'(div_rem);
                    state_next = ST_ROW_GO;
                end
            end
            ST_ROW_GO:
            begin
                state_next = ST_ROW_WAIT;
            end
            ST_ROW_WAIT:
            begin
                if (div_done)
                begin
                    row_q_next      = HEIGHT_W'(div_quo);
                    row_r_next      = HEIGHT_W'(div_rem);
                    frame_size_next = (ADDR_W + 1)'(frame_prod);
                    state_next      = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_load)
                    begin
                        load_ptr_next = (ptr_inc >= frame_size_reg) ? '0 : ADDR_W'(ptr_inc);
                    end
                    else
                    begin
                        rd_addr_next = ADDR_W'(row_base + PROD_W'(col_src_reg));
                        last_next    = frame_end;
                        state_next   = ST_READ;
                        if (row_end)
                        begin
                            col_pos_next = '0;
                            col_src_next = '0;
                            col_rem_next = '0;
                            if (frame_end)
                            begin
                                row_pos_next = '0;
                                row_src_next = '0;
                                row_rem_next = '0;
                            end
                            else
                            begin
                                row_pos_next = row_pos_reg + 1'b1;
                                row_src_next = row_src_reg + row_q_reg + HEIGHT_W'(row_wrap);
                                row_rem_next = row_wrap ? HEIGHT_W'(row_sum - {1'b0, dh})
                                                        : HEIGHT_W'(row_sum);
                            end
                        end
                        else
                        begin
                            col_pos_next = col_pos_reg + 1'b1;
                            col_src_next = col_src_reg + col_q_reg + WIDTH_W'(col_wrap);
                            col_rem_next = col_wrap ? WIDTH_W'(col_sum - {1'b0, dw})
                                                    : WIDTH_W'(col_sum);
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // Hold the read pixel until the output register has room.
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.pixel_out  = mem_rdata_reg;
                    out_data_next.last_pixel = last_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_COL_GO;
            end
        endcase

        if (cfg_valid)
        begin
            case (cfg_index)
                nnfs_pkg::REG_SRC_WIDTH:
                begin
                    src_width_next = cfg_data[nnfs_pkg::WIDTH_CFG_W-1:0];
                    cfg_write      = 1'b1;
                end
                nnfs_pkg::REG_SRC_HEIGHT:
                begin
                    src_height_next = cfg_data[nnfs_pkg::HEIGHT_CFG_W-1:0];
                    cfg_write       = 1'b1;
                end
                nnfs_pkg::REG_DST_WIDTH:
                begin
                    dst_width_next = cfg_data[nnfs_pkg::WIDTH_CFG_W-1:0];
                    cfg_write      = 1'b1;
                end
                nnfs_pkg::REG_DST_HEIGHT:
                begin
                    dst_height_next = cfg_data[nnfs_pkg::HEIGHT_CFG_W-1:0];
                    cfg_write       = 1'b1;
                end
                default:
                begin
                    cfg_write = 1'b0;
                end
            endcase
        end

        // A new geometry restarts loading and output and reruns the setup divisions.
        if (cfg_write)
        begin
            col_pos_next  = '0;
            row_pos_next  = '0;
            col_src_next  = '0;
            col_rem_next  = '0;
            row_src_next  = '0;
            row_rem_next  = '0;
            load_ptr_next = '0;
            state_next    = ST_COL_GO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COL_GO;
            src_width_reg  <= nnfs_pkg::SRC_WIDTH_RST;
            src_height_reg <= nnfs_pkg::SRC_HEIGHT_RST;
            dst_width_reg  <= nnfs_pkg::DST_WIDTH_RST;
            dst_height_reg <= nnfs_pkg::DST_HEIGHT_RST;
            col_q_reg      <= '0;
            col_r_reg      <= '0;
            row_q_reg      <= '0;
            row_r_reg      <= '0;
            frame_size_reg <= '0;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            col_src_reg    <= '0;
            col_rem_reg    <= '0;
            row_src_reg    <= '0;
            row_rem_reg    <= '0;
            load_ptr_reg   <= '0;
            rd_addr_reg    <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            dst_width_reg  <= dst_width_next;
            dst_height_reg <= dst_height_next;
            col_q_reg      <= col_q_next;
            col_r_reg      <= col_r_next;
            row_q_reg      <= row_q_next;
            row_r_reg      <= row_r_next;
            frame_size_reg <= frame_size_next;
            col_pos_reg    <= col_pos_next;
            row_pos_reg    <= row_pos_next;
            col_src_reg    <= col_src_next;
            col_rem_reg    <= col_rem_next;
            row_src_reg    <= row_src_next;
            row_rem_reg    <= row_rem_next;
            load_ptr_reg   <= load_ptr_next;
            rd_addr_reg    <= rd_addr_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    // Frame store: one write port for loads, one registered read for emits.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= in_data.pixel_in;
        end
        mem_rdata_reg <= store_mem[rd_addr_reg];
    end

    // Stepping remainders never reach the destination size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_rem_reg < dw) && (row_rem_reg < dh))
        else $error("source stepping remainder out of range");

    // Source coordinates stay inside the source frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (col_src_reg < sw) && (row_src_reg < sh))
        else $error("source coordinate outside the source frame");

    // Every emit reads inside the loaded frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ({1'b0, rd_addr_reg} < frame_size_reg))
        else $error("frame store read beyond the source frame");

    // Requests are only taken with a finished setup and the load pointer in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ({1'b0, load_ptr_reg} < frame_size_reg))
        else $error("request taken with load pointer outside the frame");

endmodule

@@ sim/nearest_neighbor_frame_scaler_test.sv @@
// Self-checking testbench for the nearest-neighbor frame scaler.
// Depends on nnfs_pkg and nearest_neighbor_frame_scaler; holds its own pixel predictor
// and drives the request, result and register channels, the first two with random idling.
module nearest_neighbor_frame_scaler_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The frame store covers the default geometry of the block.
    localparam int unsigned FRAME_W_MAX = nnfs_pkg::MAX_WIDTH_DEF;
    localparam int unsigned FRAME_H_MAX = nnfs_pkg::MAX_HEIGHT_DEF;
    localparam int unsigned STORE_DEPTH = FRAME_W_MAX * FRAME_H_MAX;

    // Lets any work still inside the block finish, such as an emit request on its way
    // to the output register.
    localparam int SETTLE_CYCLES = 8;

    // Generous bound on the whole run of a few hundred requests under the heaviest stalls,
    // with a divider pass for every register write.
    localparam int CYCLE_LIMIT = 200000;

    // Tracks the source frame as the block should hold it and predicts every
    // destination pixel that an emit request must return.
    class frame_scale_checker;

        bit [nnfs_pkg::PIXEL_BITS-1:0]   pixel_store [0:STORE_DEPTH-1];
        bit                              loaded [0:STORE_DEPTH-1];
        bit [nnfs_pkg::WIDTH_CFG_W-1:0]  src_width_reg;
        bit [nnfs_pkg::HEIGHT_CFG_W-1:0] src_height_reg;
        bit [nnfs_pkg::WIDTH_CFG_W-1:0]  dst_width_reg;
        bit [nnfs_pkg::HEIGHT_CFG_W-1:0] dst_height_reg;
        int unsigned                     load_ptr;
        int unsigned                     col;
        int unsigned                     row;
        nnfs_pkg::out_t                  expected_pixels [$];
        int                              errors;
        int                              requests;
        int                              pixels_checked;
        int                              frames_completed;

        function new();
            src_width_reg  = nnfs_pkg::SRC_WIDTH_RST;
            src_height_reg = nnfs_pkg::SRC_HEIGHT_RST;
            dst_width_reg  = nnfs_pkg::DST_WIDTH_RST;
            dst_height_reg = nnfs_pkg::DST_HEIGHT_RST;
            clear_position();
        endfunction

        function void clear_position();
            load_ptr = 0;
            col      = 0;
            row      = 0;
        endfunction

        function int unsigned fit_size(input int unsigned value, input int unsigned limit);
            if (value == 0)
            begin
                return 1;
            end
            return (value > limit) ? limit : value;
        endfunction

        function void current_sizes(output int unsigned sw, output int unsigned sh,
                                    output int unsigned dw, output int unsigned dh);
            sw = fit_size(32'(src_width_reg), FRAME_W_MAX);
            sh = fit_size(32'(src_height_reg), FRAME_H_MAX);
            dw = fit_size(32'(dst_width_reg), FRAME_W_MAX);
            dh = fit_size(32'(dst_height_reg), FRAME_H_MAX);
        endfunction

        // Store address that the next emit request reads, without touching state.
        function int unsigned source_address();
            int unsigned sw, sh, dw, dh, c, r;
            current_sizes(sw, sh, dw, dh);
            c = col;
            r = row;
            if (c >= dw || r >= dh)
            begin
                c = 0;
                r = 0;
            end
            return ((r * sh) / dh) * sw + (c * sw) / dw;
        endfunction

        // An emit may only be sent once the entry it reads has been loaded.
        function bit emit_allowed();
            return loaded[source_address()];
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_config(input logic [nnfs_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [nnfs_pkg::CFG_DATA_W-1:0] value);
            case (index)
                nnfs_pkg::REG_SRC_WIDTH:  src_width_reg  = value[nnfs_pkg::WIDTH_CFG_W-1:0];
                nnfs_pkg::REG_SRC_HEIGHT: src_height_reg = value[nnfs_pkg::HEIGHT_CFG_W-1:0];
                nnfs_pkg::REG_DST_WIDTH:  dst_width_reg  = value[nnfs_pkg::WIDTH_CFG_W-1:0];
                nnfs_pkg::REG_DST_HEIGHT: dst_height_reg = value[nnfs_pkg::HEIGHT_CFG_W-1:0];
                default: return;
            endcase
            clear_position();
        endfunction

        function void note_request(input nnfs_pkg::in_t req);
            int unsigned    sw, sh, dw, dh, addr;
            nnfs_pkg::out_t pix;
            bit             row_end;
            current_sizes(sw, sh, dw, dh);
            requests++;
            if (req.req_type == nnfs_pkg::REQ_LOAD)
            begin
                if (load_ptr >= sw * sh)
                begin
                    load_ptr = 0;
                end
                pixel_store[load_ptr] = req.pixel_in;
                loaded[load_ptr]      = 1'b1;
                load_ptr = (load_ptr + 1 >= sw * sh) ? 0 : load_ptr + 1;
            end
            else
            begin
                addr = source_address();
                if (col >= dw || row >= dh)
                begin
                    col = 0;
                    row = 0;
                end
                row_end        = (col == dw - 1);
                pix.pixel_out  = pixel_store[addr];
                pix.last_pixel = row_end && (row == dh - 1);
                expected_pixels.push_back(pix);
                if (row_end)
                begin
                    col = 0;
                    row = pix.last_pixel ? 0 : row + 1;
                end
                else
                begin
                    col++;
                end
            end
        endfunction

        function void check_pixel(input nnfs_pkg::out_t got);
            nnfs_pkg::out_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel, expected none, got pixel_out %h last_pixel %b",
                         $time, got.pixel_out, got.last_pixel);
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (want.last_pixel)
            begin
                frames_completed++;
            end
            if (got.pixel_out !== want.pixel_out)
            begin
                errors++;
                $display("%0t: pixel_out mismatch, expected %h, got %h",
                         $time, want.pixel_out, got.pixel_out);
            end
            if (got.last_pixel !== want.last_pixel)
            begin
                errors++;
                $display("%0t: last_pixel mismatch, expected %b, got %b",
                         $time, want.last_pixel, got.last_pixel);
            end
        endfunction

    endclass

    // Every input of the block starts at a known value.
    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    nnfs_pkg::in_t                    in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    nnfs_pkg::out_t                   out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [nnfs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [nnfs_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int cycle_count   = 0;
    int size_settings = 0;

    frame_scale_checker sb = new();

    nearest_neighbor_frame_scaler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side. Handshake signals are sampled right at the edge, before any
    // nonblocking update of this step lands, so the check sees exactly what the
    // block saw. The stall decision for the next cycle is drawn afterwards.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_pixel(out_data);
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding",
                     cycle_count, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sends one request. Idle cycles, if any, come before valid rises; once valid
    // is up it stays up with the same payload until the block takes the request.
    // Back-to-back requests keep valid high without lowering it in between.
    task automatic send_request(input logic kind,
                                input logic [nnfs_pkg::PIXEL_BITS-1:0] value);
        nnfs_pkg::in_t req;
        req.req_type = kind;
        req.pixel_in = value;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_request(req);
    endtask

    task automatic wait_for_pixels();
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [nnfs_pkg::CFG_INDEX_W-1:0] index,
                             input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[nnfs_pkg::CFG_DATA_W-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.note_config(index, value[nnfs_pkg::CFG_DATA_W-1:0]);
    endtask

    // Registers change only with the block idle: all pixels back, and loads that
    // give no result allowed to finish. Each write also restarts the frame
    // position, which the predictor mirrors.
    task automatic set_frame_sizes(input int unsigned sw, input int unsigned sh,
                                   input int unsigned dw, input int unsigned dh);
        wait_for_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(nnfs_pkg::REG_SRC_WIDTH, sw);
        write_reg(nnfs_pkg::REG_SRC_HEIGHT, sh);
        write_reg(nnfs_pkg::REG_DST_WIDTH, dw);
        write_reg(nnfs_pkg::REG_DST_HEIGHT, dh);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // Random mix of loads and emits. An emit goes out only when the store entry
    // it reads has been loaded; otherwise a load is sent, so large frames fill up
    // until the next destination pixel can be fetched. Emits carry random pixel
    // bits, which the block must ignore. Every fiftieth request the sender holds
    // back until all outstanding pixels have come back.
    task automatic run_stream(input int emit_target, input int emit_pct);
        int emits = 0;
        int n = 0;
        while (emits < emit_target)
        begin
            if (n % 50 == 49)
            begin
                in_valid <= 1'b0;
                wait_for_pixels();
                @(posedge clk);
            end
            if (sb.emit_allowed() && $urandom_range(99) < emit_pct)
            begin
                send_request(nnfs_pkg::REQ_EMIT, 16'($urandom_range(16'hFFFF)));
                emits++;
            end
            else
            begin
                send_request(nnfs_pkg::REQ_LOAD, 16'($urandom_range(16'hFFFF)));
            end
            n++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        int mode;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes (320x240 to 320x240) are used untouched first: extreme pixel
        // values go in, and the first pixels of the copy come straight back.
        send_request(nnfs_pkg::REQ_LOAD, 16'h0000);
        send_request(nnfs_pkg::REQ_LOAD, 16'hFFFF);
        send_request(nnfs_pkg::REQ_LOAD, 16'hA5A5);
        send_request(nnfs_pkg::REQ_LOAD, 16'h5A5A);
        send_request(nnfs_pkg::REQ_EMIT, 16'h0000);
        send_request(nnfs_pkg::REQ_EMIT, 16'hFFFF);
        send_request(nnfs_pkg::REQ_EMIT, 16'h0000);
        in_valid <= 1'b0;

        // Upscale 2x2 to 4x3 through a whole destination frame, so the last pixel
        // is flagged and the position wraps. A fifth load runs past the end of the
        // source frame and overwrites its first pixel, which the next emit returns.
        set_frame_sizes(2, 2, 4, 3);
        send_request(nnfs_pkg::REQ_LOAD, 16'hF800);
        send_request(nnfs_pkg::REQ_LOAD, 16'h07E0);
        send_request(nnfs_pkg::REQ_LOAD, 16'h001F);
        send_request(nnfs_pkg::REQ_LOAD, 16'hFFFF);
        repeat (12) send_request(nnfs_pkg::REQ_EMIT, 16'h0000);
        send_request(nnfs_pkg::REQ_LOAD, 16'h0001);
        send_request(nnfs_pkg::REQ_EMIT, 16'hFFFF);
        in_valid <= 1'b0;

        // Equal sizes must give an exact copy; no idling on either side here.
        set_idling(0, 0);
        set_frame_sizes(7, 5, 7, 5);
        run_stream(40, 50);

        // Downscale with a slow sender.
        set_idling(65, 0);
        set_frame_sizes(13, 9, 5, 4);
        run_stream(30, 50);

        // Source sizes beyond range: width clamps to the maximum, a zero height
        // counts as one, and the destination width clamps too. Slow receiver.
        set_idling(0, 65);
        set_frame_sizes(1023, 0, 1023, 2);
        run_stream(15, 50);

        // Zero destination sizes count as one, so every pixel ends a frame.
        set_idling(28, 28);
        set_frame_sizes(5, 3, 0, 0);
        run_stream(20, 50);

        // Destination sizes beyond range clamp to 512x256.
        set_idling(28, 28);
        set_frame_sizes(1023, 3, 1023, 511);
        run_stream(30, 50);

        // Largest source frame copied at equal size: the full store geometry is in
        // use, while only the first pixels of the frame are fetched.
        set_idling(0, 0);
        set_frame_sizes(512, 256, 512, 256);
        run_stream(20, 50);

        // Exact maximum destination against a single source pixel.
        set_idling(0, 65);
        set_frame_sizes(1, 1, 512, 256);
        run_stream(20, 50);

        // Random small frames, one for each idling pattern.
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: set_idling(0, 0);
                1: set_idling(65, 0);
                2: set_idling(0, 65);
                default: set_idling(28, 28);
            endcase
            set_frame_sizes($urandom_range(24, 1), $urandom_range(16, 1),
                            $urandom_range(24, 1), $urandom_range(16, 1));
            run_stream(20, $urandom_range(70, 30));
        end

        wait_for_pixels();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests over %0d frame size settings in %0d cycles.",
                 sb.requests, size_settings, cycle_count);
        $display("Checked %0d destination pixels, %0d of them closing a frame; %0d errors.",
                 sb.pixels_checked, sb.frames_completed, sb.errors);
        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ nearest_neighbor_frame_scaler.f @@
hw/rtl/nnfs_pkg.sv
hw/rtl/nnfs_div.sv
hw/rtl/nearest_neighbor_frame_scaler.sv
sim/nearest_neighbor_frame_scaler_test.sv
